// File: src/dii_pkg.sv
`default_nettype none
package dii_pkg;

    // coordinate and index widths
    localparam int COORD_W = 16;
    localparam int VID_W   = 9;
    localparam int TRI_W   = 3 * VID_W;
    localparam int TCNT_W  = 10;
    localparam int CFG_W   = 15;
    localparam int CFG_IW  = 1;

    // storage sizes
    localparam int MAX_POINTS = 256;
    localparam int PT_AW      = 8;
    localparam int PT_CW      = 9;
    localparam int MAX_TRI    = 512;
    localparam int TRI_AW     = 9;
    localparam int MAX_CAV    = 64;
    localparam int CAV_AW     = 6;
    localparam int CAV_CW     = 7;
    localparam int EDGE_W     = 2 * VID_W;

    // in-circle datapath
    localparam int DIFF_W = 22;
    localparam int MUL_W  = 23;
    localparam int PROD_W = 46;
    localparam int SQ_W   = 44;
    localparam int HALF_W = 22;
    localparam int OR_W   = 48;
    localparam int ACC_W  = 96;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_OVFL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [CFG_IW-1:0] REG_HALF_W = 1'd0;
    localparam logic [CFG_IW-1:0] REG_HALF_H = 1'd1;

    localparam logic [CFG_W-1:0] HALF_RESET = 15'd32767;

    typedef struct packed {
        logic [1:0]        status;
        logic [VID_W-1:0]  point_index;
        logic [TCNT_W-1:0] triangle_count;
        logic [VID_W-1:0]  vertex_a;
        logic [VID_W-1:0]  vertex_b;
        logic [VID_W-1:0]  vertex_c;
        logic              is_inner;
    } t_res;

endpackage
`default_nettype wire

// File: src/dii_if.sv
`default_nettype none
interface dii_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           opcode;
    logic signed [dii_pkg::COORD_W-1:0]   point_x;
    logic signed [dii_pkg::COORD_W-1:0]   point_y;
    logic [dii_pkg::TRI_AW-1:0]           triangle_index;

    modport source (output valid, opcode, point_x, point_y, triangle_index, input ready);
    modport sink   (input valid, opcode, point_x, point_y, triangle_index, output ready);
endinterface

interface dii_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [dii_pkg::VID_W-1:0]     point_index;
    logic [dii_pkg::TCNT_W-1:0]    triangle_count;
    logic [dii_pkg::VID_W-1:0]     vertex_a;
    logic [dii_pkg::VID_W-1:0]     vertex_b;
    logic [dii_pkg::VID_W-1:0]     vertex_c;
    logic                          is_inner;

    modport source (output valid, status, point_index, triangle_count, vertex_a, vertex_b,
                    vertex_c, is_inner, input ready);
    modport sink   (input valid, status, point_index, triangle_count, vertex_a, vertex_b,
                    vertex_c, is_inner, output ready);
endinterface
`default_nettype wire

// File: src/delaunay_incremental_insert_unit.sv
// Incremental 2D Delaunay triangulation (Bowyer-Watson), integer coordinates.
// i_req carries one command per transaction: insert point, read triangle, clear.
// o_rsp returns exactly one result per command through an output register, so
// a waiting result does not block the next command from being accepted.
// i_cfg_* writes the super triangle half extents; they take effect on clear, and
// reset restores the default half extent of 32767. One command is in flight at a
// time. An insert scans every table entry for the in-circle test (one shared
// 23x23 multiplier does 26 products per triangle), then searches the boundary
// edges of the cavity, compacts the table and appends one new triangle per
// boundary edge. The triangle table memory port sets the pace of everything
// after the scan.
// Reset: the S_INIT state writes the super triangle into table entry 0; the input is
// not ready during it. Clear does the same in its accept cycle.
// A stalled receiver holds the result in the output register; one more result
// waits internally, after which the block stops accepting commands.
`default_nettype none
module delaunay_incremental_insert_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [dii_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  wire logic [dii_pkg::CFG_W-1:0]   i_cfg_data,
    dii_in_if.sink                           i_req,
    dii_out_if.source                        o_rsp
);
    import dii_pkg::*;

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_SCAN_T = 5'd2;
    localparam logic [4:0] S_SCAN_V = 5'd3;
    localparam logic [4:0] S_SCAN_M = 5'd4;
    localparam logic [4:0] S_SCAN_D = 5'd5;
    localparam logic [4:0] S_BE_I   = 5'd6;
    localparam logic [4:0] S_BE_IT  = 5'd7;
    localparam logic [4:0] S_BE_OWN = 5'd8;
    localparam logic [4:0] S_BE_J   = 5'd9;
    localparam logic [4:0] S_BE_E   = 5'd10;
    localparam logic [4:0] S_CHK    = 5'd11;
    localparam logic [4:0] S_CP_A   = 5'd12;
    localparam logic [4:0] S_CP_B   = 5'd13;
    localparam logic [4:0] S_AP_A   = 5'd14;
    localparam logic [4:0] S_AP_B   = 5'd15;
    localparam logic [4:0] S_RD     = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;

    localparam logic [4:0] K_LAST = 5'd26;   // last accumulate cycle of the program
    localparam logic [TRI_W-1:0] SUPER_TRI = {9'd0, 9'd1, 9'd2};

    function automatic logic [VID_W-1:0] vtx(input logic [TRI_W-1:0] w, input logic [1:0] s);
        case (s)
            2'd0:    vtx = w[26:18];
            2'd1:    vtx = w[17:9];
            default: vtx = w[8:0];
        endcase
    endfunction

    function automatic logic edge_hit(input logic [VID_W-1:0] u, input logic [VID_W-1:0] v,
                                      input logic [TRI_W-1:0] w);
        logic [VID_W-1:0] a, b, c;
        a = w[26:18];
        b = w[17:9];
        c = w[8:0];
        edge_hit = (u == a && v == b) || (u == b && v == a) ||
                   (u == b && v == c) || (u == c && v == b) ||
                   (u == c && v == a) || (u == a && v == c);
    endfunction

    // memories and registered read data
    logic [2*COORD_W-1:0] pt_mem  [MAX_POINTS];
    logic [TRI_W-1:0]     tri_mem [MAX_TRI];
    logic [TRI_AW-1:0]    cav_mem [MAX_CAV];
    logic [EDGE_W-1:0]    be_mem  [MAX_CAV];
    logic [2*COORD_W-1:0] r_pt_q;
    logic [TRI_W-1:0]     r_tri_q;
    logic [TRI_AW-1:0]    r_cav_q;
    logic [EDGE_W-1:0]    r_be_q;

    logic                 pt_re, pt_we, tri_re, tri_we, cav_re, cav_we, be_re, be_we;
    logic [PT_AW-1:0]     pt_raddr, pt_waddr;
    logic [2*COORD_W-1:0] pt_wdata;
    logic [TRI_AW-1:0]    tri_raddr, tri_waddr;
    logic [TRI_W-1:0]     tri_wdata;
    logic [CAV_AW-1:0]    cav_raddr, cav_waddr, be_raddr, be_waddr;
    logic [TRI_AW-1:0]    cav_wdata;
    logic [EDGE_W-1:0]    be_wdata;

    // control state
    logic [4:0]        r_state, n_state;
    logic [CFG_W-1:0]  r_cfg_w, r_cfg_h, r_sw, r_sh, n_sw, n_sh;
    logic [PT_CW-1:0]  r_pc, n_pc;
    logic [TCNT_W-1:0] r_tc, n_tc;
    logic              r_out_valid, n_out_valid;

    // working registers
    logic signed [COORD_W-1:0] r_px, r_py, n_px, n_py;
    logic [TCNT_W-1:0] r_t, n_t, r_w, n_w;
    logic [1:0]        r_vi, n_vi, r_e, n_e;
    logic [4:0]        r_k, n_k, r_pstep, n_pstep;
    logic [CAV_CW-1:0] r_nbad, n_nbad, r_nedge, n_nedge, r_i, n_i;
    logic [CAV_CW-1:0] r_jr, n_jr, r_j1, n_j1, r_j2, n_j2, r_kc, n_kc;
    logic              r_v1, n_v1, r_v2, n_v2, r_pvalid, n_pvalid;
    logic [TRI_W-1:0]  r_own, n_own;
    logic [2:0]        r_shared, n_shared;
    logic [VID_W-1:0]  r_pidx, n_pidx;
    logic signed [DIFF_W-1:0] r_dx [3];
    logic signed [DIFF_W-1:0] r_dy [3];
    logic signed [DIFF_W-1:0] n_dx [3];
    logic signed [DIFF_W-1:0] n_dy [3];
    logic signed [SQ_W-1:0]   r_sa, r_sb, r_sc, r_ca, r_cb, r_cc;
    logic signed [SQ_W-1:0]   n_sa, n_sb, n_sc, n_ca, n_cb, n_cc;
    logic signed [OR_W-1:0]   r_or, n_or;
    logic signed [ACC_W-1:0]  r_det, n_det;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    t_res r_res, n_res, r_out, n_out;

    // combinational helpers
    logic [DIFF_W-1:0]        sup_w, sup_h;
    logic signed [MUL_W-1:0]  m_a, m_b;
    logic [4:0]               q;
    logic signed [SQ_W-1:0]   op_l, op_r;
    logic signed [ACC_W-1:0]  pext, padj;
    logic [VID_W-1:0]         cap_id, rd_id, eu, ev;
    logic signed [DIFF_W-1:0] cap_x, cap_y;
    logic [TCNT_W:0]          new_cnt;
    logic                     det_pos, or_pos, bad;

    // super vertex offsets: 20 * half extent = 16x + 4x
    assign sup_w = ({7'd0, r_sw} << 4) + ({7'd0, r_sw} << 2);
    assign sup_h = ({7'd0, r_sh} << 4) + ({7'd0, r_sh} << 2);

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.point_index    = r_out.point_index;
    assign o_rsp.triangle_count = r_out.triangle_count;
    assign o_rsp.vertex_a       = r_out.vertex_a;
    assign o_rsp.vertex_b       = r_out.vertex_b;
    assign o_rsp.vertex_c       = r_out.vertex_c;
    assign o_rsp.is_inner       = r_out.is_inner;

    // multiplier operand program: squares, cofactors, orientation, then the
    // three 44x44 det terms split into 22-bit halves
    always_comb begin
        q    = r_k - 5'd14;
        op_l = (q[3:2] == 2'd0) ? r_sa : (q[3:2] == 2'd1) ? r_sb : r_sc;
        op_r = (q[3:2] == 2'd0) ? r_ca : (q[3:2] == 2'd1) ? r_cb : r_cc;
        m_a  = '0;
        m_b  = '0;
        case (r_k)
            5'd0:  begin m_a = MUL_W'(r_dx[0]); m_b = MUL_W'(r_dx[0]); end
            5'd1:  begin m_a = MUL_W'(r_dy[0]); m_b = MUL_W'(r_dy[0]); end
            5'd2:  begin m_a = MUL_W'(r_dx[1]); m_b = MUL_W'(r_dx[1]); end
            5'd3:  begin m_a = MUL_W'(r_dy[1]); m_b = MUL_W'(r_dy[1]); end
            5'd4:  begin m_a = MUL_W'(r_dx[2]); m_b = MUL_W'(r_dx[2]); end
            5'd5:  begin m_a = MUL_W'(r_dy[2]); m_b = MUL_W'(r_dy[2]); end
            5'd6:  begin m_a = MUL_W'(r_dx[1]); m_b = MUL_W'(r_dy[2]); end
            5'd7:  begin m_a = MUL_W'(r_dx[2]); m_b = MUL_W'(r_dy[1]); end
            5'd8:  begin m_a = MUL_W'(r_dx[0]); m_b = MUL_W'(r_dy[2]); end
            5'd9:  begin m_a = MUL_W'(r_dx[2]); m_b = MUL_W'(r_dy[0]); end
            5'd10: begin m_a = MUL_W'(r_dx[0]); m_b = MUL_W'(r_dy[1]); end
            5'd11: begin m_a = MUL_W'(r_dx[1]); m_b = MUL_W'(r_dy[0]); end
            5'd12: begin
                m_a = MUL_W'(r_dx[0]) - MUL_W'(r_dx[1]);
                m_b = MUL_W'(r_dy[2]) - MUL_W'(r_dy[1]);
            end
            5'd13: begin
                m_a = MUL_W'(r_dy[0]) - MUL_W'(r_dy[1]);
                m_b = MUL_W'(r_dx[2]) - MUL_W'(r_dx[1]);
            end
            default: begin
                m_a = q[1] ? {op_l[SQ_W-1], op_l[SQ_W-1:HALF_W]} : {1'b0, op_l[HALF_W-1:0]};
                m_b = q[0] ? {op_r[SQ_W-1], op_r[SQ_W-1:HALF_W]} : {1'b0, op_r[HALF_W-1:0]};
            end
        endcase
    end

    always_comb begin
        // sign-extended product, aligned for the det partial products
        pext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        case (r_pstep - 5'd14)
            5'd0, 5'd4, 5'd8:  padj = pext;
            5'd3, 5'd7, 5'd11: padj = pext <<< (2 * HALF_W);
            default:           padj = pext <<< HALF_W;
        endcase
        det_pos = !r_det[ACC_W-1] && (r_det != '0);
        or_pos  = !r_or[OR_W-1] && (r_or != '0);
        bad     = or_pos ? det_pos : r_det[ACC_W-1];
        // vertex being captured during fetch
        cap_id  = vtx(r_tri_q, r_vi - 2'd1);
        rd_id   = vtx(r_tri_q, r_vi);
        case (cap_id)
            9'd0: begin
                cap_x = -DIFF_W'(signed'(sup_w)) - DIFF_W'(r_px);
                cap_y = -DIFF_W'(signed'(sup_h)) - DIFF_W'(r_py);
            end
            9'd1: begin
                cap_x = -DIFF_W'(r_px);
                cap_y = DIFF_W'(signed'(sup_h)) - DIFF_W'(r_py);
            end
            9'd2: begin
                cap_x = DIFF_W'(signed'(sup_w)) - DIFF_W'(r_px);
                cap_y = -DIFF_W'(signed'(sup_h)) - DIFF_W'(r_py);
            end
            default: begin
                cap_x = DIFF_W'(signed'(r_pt_q[COORD_W-1:0])) - DIFF_W'(r_px);
                cap_y = DIFF_W'(signed'(r_pt_q[2*COORD_W-1:COORD_W])) - DIFF_W'(r_py);
            end
        endcase
        // edge e of the cavity triangle under test: (a,b), (b,c), (c,a)
        eu      = vtx(r_own, r_e);
        ev      = vtx(r_own, (r_e == 2'd2) ? 2'd0 : r_e + 2'd1);
        new_cnt = {1'b0, r_tc} - {4'd0, r_nbad} + {4'd0, r_nedge};
    end

    always_comb begin
        n_state     = r_state;
        n_sw        = r_sw;
        n_sh        = r_sh;
        n_pc        = r_pc;
        n_tc        = r_tc;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        n_res       = r_res;
        n_px = r_px;  n_py = r_py;  n_t = r_t;  n_w = r_w;
        n_vi = r_vi;  n_e = r_e;    n_k = r_k;  n_pstep = r_pstep;
        n_nbad = r_nbad;  n_nedge = r_nedge;  n_i = r_i;
        n_jr = r_jr;  n_j1 = r_j1;  n_j2 = r_j2;  n_kc = r_kc;
        n_v1 = r_v1;  n_v2 = r_v2;  n_pvalid = 1'b0;
        n_own = r_own;  n_shared = r_shared;  n_pidx = r_pidx;
        n_dx = r_dx;  n_dy = r_dy;
        n_sa = r_sa;  n_sb = r_sb;  n_sc = r_sc;
        n_ca = r_ca;  n_cb = r_cb;  n_cc = r_cc;
        n_or = r_or;  n_det = r_det;  n_prod = r_prod;
        pt_re = 1'b0;  pt_raddr = '0;  pt_we = 1'b0;  pt_waddr = '0;  pt_wdata = '0;
        tri_re = 1'b0; tri_raddr = '0; tri_we = 1'b0; tri_waddr = '0; tri_wdata = '0;
        cav_re = 1'b0; cav_raddr = '0; cav_we = 1'b0; cav_waddr = '0; cav_wdata = '0;
        be_re = 1'b0;  be_raddr = '0;  be_we = 1'b0;  be_waddr = '0;  be_wdata = '0;

        // accumulate the product issued last cycle
        if (r_pvalid) begin
            case (r_pstep)
                5'd0:  n_sa = r_prod[SQ_W-1:0];
                5'd1:  n_sa = r_sa + r_prod[SQ_W-1:0];
                5'd2:  n_sb = r_prod[SQ_W-1:0];
                5'd3:  n_sb = r_sb + r_prod[SQ_W-1:0];
                5'd4:  n_sc = r_prod[SQ_W-1:0];
                5'd5:  n_sc = r_sc + r_prod[SQ_W-1:0];
                5'd6:  n_ca = r_prod[SQ_W-1:0];
                5'd7:  n_ca = r_ca - r_prod[SQ_W-1:0];
                5'd8:  n_cb = r_prod[SQ_W-1:0];
                5'd9:  n_cb = r_cb - r_prod[SQ_W-1:0];
                5'd10: n_cc = r_prod[SQ_W-1:0];
                5'd11: n_cc = r_cc - r_prod[SQ_W-1:0];
                5'd12: n_or = {{(OR_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                5'd13: n_or = r_or - {{(OR_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                5'd14: n_det = padj;
                5'd18, 5'd19, 5'd20, 5'd21: n_det = r_det - padj;   // middle term subtracts
                default: n_det = r_det + padj;
            endcase
        end

        case (r_state)
            S_INIT: begin
                tri_we    = 1'b1;
                tri_wdata = SUPER_TRI;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_res                = '0;
                    n_res.triangle_count = r_tc;
                    n_state              = S_DONE;
                    case (i_req.opcode)
                        OP_INSERT: begin
                            n_px = i_req.point_x;
                            n_py = i_req.point_y;
                            if (r_pc == PT_CW'(MAX_POINTS)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_nbad  = '0;
                                n_nedge = '0;
                                n_t     = '0;
                                n_state = S_SCAN_T;
                            end
                        end
                        OP_READ: begin
                            if ({1'b0, i_req.triangle_index} >= r_tc) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                tri_re    = 1'b1;
                                tri_raddr = i_req.triangle_index;
                                n_state   = S_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_sw                 = r_cfg_w;
                            n_sh                 = r_cfg_h;
                            n_pc                 = '0;
                            n_tc                 = TCNT_W'(1);
                            tri_we               = 1'b1;
                            tri_wdata            = SUPER_TRI;
                            n_res.triangle_count = TCNT_W'(1);
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                n_res.vertex_a = vtx(r_tri_q, 2'd0);
                n_res.vertex_b = vtx(r_tri_q, 2'd1);
                n_res.vertex_c = vtx(r_tri_q, 2'd2);
                n_res.is_inner = (vtx(r_tri_q, 2'd0) >= 9'd3) && (vtx(r_tri_q, 2'd1) >= 9'd3)
                                 && (vtx(r_tri_q, 2'd2) >= 9'd3);
                n_state = S_DONE;
            end
            // ---- in-circle scan over the whole table
            S_SCAN_T: begin
                if (r_t == r_tc) begin
                    n_i     = '0;
                    n_state = (r_nbad == '0) ? S_CHK : S_BE_I;
                end else begin
                    tri_re    = 1'b1;
                    tri_raddr = r_t[TRI_AW-1:0];
                    n_vi      = '0;
                    n_state   = S_SCAN_V;
                end
            end
            S_SCAN_V: begin
                if (r_vi != 2'd3) begin
                    pt_re    = 1'b1;
                    pt_raddr = PT_AW'(rd_id - 9'd3);
                end
                if (r_vi != 2'd0) begin
                    n_dx[r_vi - 2'd1] = cap_x;
                    n_dy[r_vi - 2'd1] = cap_y;
                end
                n_vi = r_vi + 2'd1;
                if (r_vi == 2'd3) begin
                    n_k     = '0;
                    n_state = S_SCAN_M;
                end
            end
            S_SCAN_M: begin
                if (r_k != K_LAST) begin
                    n_prod   = m_a * m_b;
                    n_pvalid = 1'b1;
                    n_pstep  = r_k;
                    n_k      = r_k + 5'd1;
                end else begin
                    n_state = S_SCAN_D;
                end
            end
            S_SCAN_D: begin
                n_t     = r_t + TCNT_W'(1);
                n_state = S_SCAN_T;
                if (bad) begin
                    if (r_nbad == CAV_CW'(MAX_CAV)) begin
                        n_res                = '0;
                        n_res.status         = ST_OVFL;
                        n_res.triangle_count = r_tc;
                        n_state              = S_DONE;
                    end else begin
                        cav_we    = 1'b1;
                        cav_waddr = r_nbad[CAV_AW-1:0];
                        cav_wdata = r_t[TRI_AW-1:0];
                        n_nbad    = r_nbad + CAV_CW'(1);
                    end
                end
            end
            // ---- boundary edges: edges of each removed triangle not in another
            S_BE_I: begin
                cav_re    = 1'b1;
                cav_raddr = r_i[CAV_AW-1:0];
                n_state   = S_BE_IT;
            end
            S_BE_IT: begin
                tri_re    = 1'b1;
                tri_raddr = r_cav_q;
                n_state   = S_BE_OWN;
            end
            S_BE_OWN: begin
                n_own    = r_tri_q;
                n_shared = '0;
                n_jr     = '0;
                n_v1     = 1'b0;
                n_v2     = 1'b0;
                n_state  = S_BE_J;
            end
            S_BE_J: begin
                // three-deep walk: cavity index read, triangle read, compare
                n_v1 = 1'b0;
                n_v2 = 1'b0;
                if (r_jr < r_nbad) begin
                    cav_re    = 1'b1;
                    cav_raddr = r_jr[CAV_AW-1:0];
                    n_jr      = r_jr + CAV_CW'(1);
                    n_j1      = r_jr;
                    n_v1      = 1'b1;
                end
                if (r_v1) begin
                    tri_re    = 1'b1;
                    tri_raddr = r_cav_q;
                    n_j2      = r_j1;
                    n_v2      = 1'b1;
                end
                if (r_v2 && r_j2 != r_i) begin
                    n_shared = r_shared |
                               {edge_hit(r_own[8:0], r_own[26:18], r_tri_q),
                                edge_hit(r_own[17:9], r_own[8:0], r_tri_q),
                                edge_hit(r_own[26:18], r_own[17:9], r_tri_q)};
                end
                if (r_jr == r_nbad && !r_v1 && !r_v2) begin
                    n_e     = '0;
                    n_state = S_BE_E;
                end
            end
            S_BE_E: begin
                if (!r_shared[r_e] && r_nedge == CAV_CW'(MAX_CAV)) begin
                    n_res                = '0;
                    n_res.status         = ST_OVFL;
                    n_res.triangle_count = r_tc;
                    n_state              = S_DONE;
                end else begin
                    if (!r_shared[r_e]) begin
                        be_we    = 1'b1;
                        be_waddr = r_nedge[CAV_AW-1:0];
                        be_wdata = {eu, ev};
                        n_nedge  = r_nedge + CAV_CW'(1);
                    end
                    n_e = r_e + 2'd1;
                    if (r_e == 2'd2) begin
                        n_i     = r_i + CAV_CW'(1);
                        n_state = (r_i + CAV_CW'(1) == r_nbad) ? S_CHK : S_BE_I;
                    end
                end
            end
            S_CHK: begin
                if (new_cnt > (TCNT_W + 1)'(MAX_TRI)) begin
                    n_res                = '0;
                    n_res.status         = ST_OVFL;
                    n_res.triangle_count = r_tc;
                    n_state              = S_DONE;
                end else begin
                    pt_we    = 1'b1;
                    pt_waddr = r_pc[PT_AW-1:0];
                    pt_wdata = {r_py, r_px};
                    n_pc     = r_pc + PT_CW'(1);
                    n_pidx   = r_pc + 9'd3;
                    n_t      = '0;
                    n_kc     = '0;
                    n_w      = '0;
                    n_i      = '0;
                    n_state  = (r_tc == '0) ? S_AP_A : S_CP_A;
                end
            end
            // ---- compaction in place, skipping removed entries
            S_CP_A: begin
                tri_re    = 1'b1;
                tri_raddr = r_t[TRI_AW-1:0];
                cav_re    = 1'b1;
                cav_raddr = r_kc[CAV_AW-1:0];
                n_state   = S_CP_B;
            end
            S_CP_B: begin
                if (r_kc < r_nbad && r_cav_q == r_t[TRI_AW-1:0]) begin
                    n_kc = r_kc + CAV_CW'(1);
                end else begin
                    tri_we    = 1'b1;
                    tri_waddr = r_w[TRI_AW-1:0];
                    tri_wdata = r_tri_q;
                    n_w       = r_w + TCNT_W'(1);
                end
                n_t     = r_t + TCNT_W'(1);
                n_state = (r_t + TCNT_W'(1) == r_tc) ? S_AP_A : S_CP_A;
            end
            // ---- append fan of new triangles
            S_AP_A: begin
                if (r_i == r_nedge) begin
                    n_tc                 = r_w;
                    n_res                = '0;
                    n_res.point_index    = r_pidx;
                    n_res.triangle_count = r_w;
                    n_state              = S_DONE;
                end else begin
                    be_re    = 1'b1;
                    be_raddr = r_i[CAV_AW-1:0];
                    n_state  = S_AP_B;
                end
            end
            S_AP_B: begin
                tri_we    = 1'b1;
                tri_waddr = r_w[TRI_AW-1:0];
                tri_wdata = {r_be_q, r_pidx};
                n_w       = r_w + TCNT_W'(1);
                n_i       = r_i + CAV_CW'(1);
                n_state   = S_AP_A;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cfg_w     <= HALF_RESET;
            r_cfg_h     <= HALF_RESET;
            r_sw        <= HALF_RESET;
            r_sh        <= HALF_RESET;
            r_pc        <= '0;
            r_tc        <= TCNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sw        <= n_sw;
            r_sh        <= n_sh;
            r_pc        <= n_pc;
            r_tc        <= n_tc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_idx == REG_HALF_W) begin
                r_cfg_w <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == REG_HALF_H) begin
                r_cfg_h <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= n_px;  r_py <= n_py;  r_t <= n_t;  r_w <= n_w;
        r_vi <= n_vi;  r_e <= n_e;    r_k <= n_k;  r_pstep <= n_pstep;
        r_nbad <= n_nbad;  r_nedge <= n_nedge;  r_i <= n_i;
        r_jr <= n_jr;  r_j1 <= n_j1;  r_j2 <= n_j2;  r_kc <= n_kc;
        r_v1 <= n_v1;  r_v2 <= n_v2;  r_pvalid <= n_pvalid;
        r_own <= n_own;  r_shared <= n_shared;  r_pidx <= n_pidx;
        r_dx <= n_dx;  r_dy <= n_dy;
        r_sa <= n_sa;  r_sb <= n_sb;  r_sc <= n_sc;
        r_ca <= n_ca;  r_cb <= n_cb;  r_cc <= n_cc;
        r_or <= n_or;  r_det <= n_det;  r_prod <= n_prod;
        r_res <= n_res;  r_out <= n_out;
    end

    // storage: one write and one registered read per memory per cycle
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        if (pt_re) begin
            r_pt_q <= pt_mem[pt_raddr];
        end
        if (tri_we) begin
            tri_mem[tri_waddr] <= tri_wdata;
        end
        if (tri_re) begin
            r_tri_q <= tri_mem[tri_raddr];
        end
        if (cav_we) begin
            cav_mem[cav_waddr] <= cav_wdata;
        end
        if (cav_re) begin
            r_cav_q <= cav_mem[cav_raddr];
        end
        if (be_we) begin
            be_mem[be_waddr] <= be_wdata;
        end
        if (be_re) begin
            r_be_q <= be_mem[be_raddr];
        end
    end

    // compaction never writes ahead of its read pointer
    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CP_B) |-> (r_w <= r_t))
        else $error("compaction write index passed read index");

    a_cavity_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_D) |-> (r_nbad <= CAV_CW'(MAX_CAV)))
        else $error("cavity list overrun");

    a_table_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tc <= TCNT_W'(MAX_TRI)))
        else $error("triangle count beyond table");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside done state");

endmodule
`default_nettype wire
